>>> rtl/assert_macros.svh
// Assertion helpers shared by the blob centroid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/cbbc_pkg.sv
package cbbc_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    // Field and accumulator widths
    localparam int CH_W    = 8;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int COUNT_W = 17;
    localparam int TOTAL_W = 25;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = TOTAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BLUE_LOWER  = 3'd0,
        REG_BLUE_UPPER  = 3'd1,
        REG_GREEN_LOWER = 3'd2,
        REG_GREEN_UPPER = 3'd3,
        REG_RED_LOWER   = 3'd4,
        REG_RED_UPPER   = 3'd5
    } t_reg_idx;

    localparam logic [CH_W-1:0] RST_BLUE_LOWER  = 8'd130;
    localparam logic [CH_W-1:0] RST_BLUE_UPPER  = 8'd150;
    localparam logic [CH_W-1:0] RST_GREEN_LOWER = 8'd160;
    localparam logic [CH_W-1:0] RST_GREEN_UPPER = 8'd190;
    localparam logic [CH_W-1:0] RST_RED_LOWER   = 8'd170;
    localparam logic [CH_W-1:0] RST_RED_UPPER   = 8'd210;

    typedef struct packed {
        logic [CH_W-1:0] blue_lower;
        logic [CH_W-1:0] blue_upper;
        logic [CH_W-1:0] green_lower;
        logic [CH_W-1:0] green_upper;
        logic [CH_W-1:0] red_lower;
        logic [CH_W-1:0] red_upper;
    } t_thresh;

    typedef enum logic [1:0] {
        ST_ACCUM = 2'd0,
        ST_DIV   = 2'd1,
        ST_HOLD  = 2'd2
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic pix_ready;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pix_valid;
        logic pix_last;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

>>> rtl/cbbc_pixel_if.sv
interface cbbc_pixel_if;
    import cbbc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             frame_end;

    modport source (output valid, blue, green, red, column, row, frame_end, input ready);
    modport sink   (input valid, blue, green, red, column, row, frame_end, output ready);
endinterface

>>> rtl/cbbc_result_if.sv
interface cbbc_result_if;
    import cbbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   centroid_column;
    logic [ROW_W-1:0]   centroid_row;
    logic               found;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, centroid_column, centroid_row, found, match_count,
                    input ready);
    modport sink   (input valid, centroid_column, centroid_row, found, match_count,
                    output ready);
endinterface

>>> rtl/cbbc_regs.sv
module cbbc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbbc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cbbc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cbbc_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output cbbc_pkg::t_thresh             o_thresh
);
    import cbbc_pkg::*;

    t_thresh              r_thresh;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;
    logic [CH_W-1:0]      w_rd;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    // Write the addressed threshold; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.blue_lower  <= RST_BLUE_LOWER;
            r_thresh.blue_upper  <= RST_BLUE_UPPER;
            r_thresh.green_lower <= RST_GREEN_LOWER;
            r_thresh.green_upper <= RST_GREEN_UPPER;
            r_thresh.red_lower   <= RST_RED_LOWER;
            r_thresh.red_upper   <= RST_RED_UPPER;
        end else if (w_wr) begin
            case (w_idx)
                REG_BLUE_LOWER:  r_thresh.blue_lower  <= pwdata[CH_W-1:0];
                REG_BLUE_UPPER:  r_thresh.blue_upper  <= pwdata[CH_W-1:0];
                REG_GREEN_LOWER: r_thresh.green_lower <= pwdata[CH_W-1:0];
                REG_GREEN_UPPER: r_thresh.green_upper <= pwdata[CH_W-1:0];
                REG_RED_LOWER:   r_thresh.red_lower   <= pwdata[CH_W-1:0];
                REG_RED_UPPER:   r_thresh.red_upper   <= pwdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_BLUE_LOWER:  w_rd = r_thresh.blue_lower;
            REG_BLUE_UPPER:  w_rd = r_thresh.blue_upper;
            REG_GREEN_LOWER: w_rd = r_thresh.green_lower;
            REG_GREEN_UPPER: w_rd = r_thresh.green_upper;
            REG_RED_LOWER:   w_rd = r_thresh.red_lower;
            REG_RED_UPPER:   w_rd = r_thresh.red_upper;
            default:         w_rd = '0;
        endcase
    end

    assign prdata   = {{(APB_DATA_W-CH_W){1'b0}}, w_rd};
    assign o_thresh = r_thresh;
endmodule

>>> rtl/cbbc_ctrl.sv
`include "assert_macros.svh"

module cbbc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbbc_pkg::t_dp_status i_status,
    output cbbc_pkg::t_dp_cmd    o_cmd
);
    import cbbc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence: take pixels, divide after the frame end, hand over the result
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_ACCUM: begin
                o_cmd.pix_ready = 1'b1;
                if (i_status.pix_valid && i_status.pix_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    `ASSERT_NEVER(a_ready_while_div, o_cmd.pix_ready && (o_cmd.div_step || o_cmd.out_load),
        "pixel taken while the divider or output load is active")
    `ASSERT_CLK(a_load_returns, o_cmd.out_load |=> (r_state == ST_ACCUM),
        "result load not followed by pixel intake")
    `ASSERT_CLK(a_frame_end_divides,
        (o_cmd.pix_ready && i_status.pix_valid && i_status.pix_last) |=> (r_state == ST_DIV),
        "frame end beat did not start the division")
endmodule

>>> rtl/cbbc_dp.sv
`include "assert_macros.svh"

module cbbc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbbc_pkg::t_thresh    i_thresh,
    input  cbbc_pkg::t_dp_cmd    i_cmd,
    output cbbc_pkg::t_dp_status o_status,
    cbbc_pixel_if.sink           i_pix,
    cbbc_result_if.source        o_res
);
    import cbbc_pkg::*;

    // Accumulators
    logic [COUNT_W-1:0] r_matched,   n_matched;
    logic [TOTAL_W-1:0] r_col_total, n_col_total;
    logic [TOTAL_W-1:0] r_row_total, n_row_total;

    // Divider: shared step counter, two restoring dividers by the same count
    logic [COUNT_W-1:0] r_div_cnt;
    logic [TOTAL_W-1:0] r_col_q, r_row_q;
    logic [COUNT_W-1:0] r_col_rem, r_row_rem;
    logic [STEP_W-1:0]  r_step;

    // Output register
    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_found;
    logic [COUNT_W-1:0] r_out_count;

    logic w_take;
    logic w_match;
    logic [TOTAL_W:0] w_col_sum, w_row_sum;
    logic [COUNT_W+TOTAL_W-1:0] w_col_next, w_row_next;

    // One restoring step: returns {remainder, shifted quotient}
    function automatic logic [COUNT_W+TOTAL_W-1:0] div_step(
        input logic [COUNT_W-1:0] rem,
        input logic [TOTAL_W-1:0] q,
        input logic [COUNT_W-1:0] d
    );
        logic [COUNT_W:0] trial;
        logic [COUNT_W:0] diff;
        trial = {rem, q[TOTAL_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            div_step = {diff[COUNT_W-1:0], q[TOTAL_W-2:0], 1'b1};
        end else begin
            div_step = {trial[COUNT_W-1:0], q[TOTAL_W-2:0], 1'b0};
        end
    endfunction

    assign w_take = i_pix.valid && i_cmd.pix_ready;

    // Match: inside frame and each channel strictly inside its bounds
    assign w_match = (32'(i_pix.column) < 32'(FRAME_WIDTH))
                  && (32'(i_pix.row) < 32'(FRAME_HEIGHT))
                  && (i_pix.blue  > i_thresh.blue_lower)  && (i_pix.blue  < i_thresh.blue_upper)
                  && (i_pix.green > i_thresh.green_lower) && (i_pix.green < i_thresh.green_upper)
                  && (i_pix.red   > i_thresh.red_lower)   && (i_pix.red   < i_thresh.red_upper);

    // Saturating accumulate
    assign w_col_sum = {1'b0, r_col_total} + (TOTAL_W+1)'(i_pix.column);
    assign w_row_sum = {1'b0, r_row_total} + (TOTAL_W+1)'(i_pix.row);

    always_comb begin
        n_matched   = r_matched;
        n_col_total = r_col_total;
        n_row_total = r_row_total;
        if (w_match) begin
            n_matched   = (&r_matched) ? r_matched : r_matched + 1'b1;
            n_col_total = w_col_sum[TOTAL_W] ? '1 : w_col_sum[TOTAL_W-1:0];
            n_row_total = w_row_sum[TOTAL_W] ? '1 : w_row_sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched   <= '0;
            r_col_total <= '0;
            r_row_total <= '0;
        end else if (w_take) begin
            if (i_pix.frame_end) begin
                r_matched   <= '0;
                r_col_total <= '0;
                r_row_total <= '0;
            end else begin
                r_matched   <= n_matched;
                r_col_total <= n_col_total;
                r_row_total <= n_row_total;
            end
        end
    end

    assign w_col_next = div_step(r_col_rem, r_col_q, r_div_cnt);
    assign w_row_next = div_step(r_row_rem, r_row_q, r_div_cnt);

    // Snapshot totals at frame end, then advance one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (w_take && i_pix.frame_end) begin
            r_div_cnt <= n_matched;
            r_col_q   <= n_col_total;
            r_row_q   <= n_row_total;
            r_col_rem <= '0;
            r_row_rem <= '0;
            r_step    <= '0;
        end else if (i_cmd.div_step) begin
            {r_col_rem, r_col_q} <= w_col_next;
            {r_row_rem, r_row_q} <= w_row_next;
            r_step               <= r_step + 1'b1;
        end
    end

    // Output register: load the clamped quotients, or zeros with no match, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_div_cnt;
            r_out_found <= (r_div_cnt != '0);
            if (r_div_cnt == '0) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_out_col <= (|r_col_q[TOTAL_W-1:COL_W]) ? '1 : r_col_q[COL_W-1:0];
                r_out_row <= (|r_row_q[TOTAL_W-1:ROW_W]) ? '1 : r_row_q[ROW_W-1:0];
            end
        end
    end

    assign i_pix.ready           = i_cmd.pix_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.centroid_column = r_out_col;
    assign o_res.centroid_row    = r_out_row;
    assign o_res.found           = r_out_found;
    assign o_res.match_count     = r_out_count;

    assign o_status.pix_valid = i_pix.valid;
    assign o_status.pix_last  = i_pix.frame_end;
    assign o_status.div_last  = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_status.out_busy  = r_out_valid && !o_res.ready;

    `ASSERT_CLK(a_load_sets_valid, i_cmd.out_load |=> r_out_valid,
        "result load did not raise the output valid")
    `ASSERT_CLK(a_found_matches_count,
        r_out_valid |-> (r_out_found == (r_out_count != '0)),
        "found flag disagrees with the match count")
    `ASSERT_NEVER(a_step_overrun, i_cmd.div_step && (32'(r_step) >= DIV_STEPS),
        "divider stepped past its last quotient bit")
endmodule

>>> rtl/color_box_blob_centroid_core.sv
// Color box blob centroid: one RGB pixel beat per clock with its column, row and
// frame-end mark; a pixel inside the frame whose blue, green and red each lie
// strictly between their lower and upper thresholds (APB registers 0..5 at byte
// addresses 0x00..0x14) adds to a saturating match count, column sum and row sum.
// The frame-end beat is counted too, then intake pauses while a shared-counter
// restoring divider produces both centroids, one quotient bit per cycle, and the
// output register is loaded; intake resumes after that load, or later if the
// previous result still waits.
// One result beat per frame: clamped centroids, found and match count; with no
// match found and both centroids read 0. Between frame ends the block takes one
// pixel per clock.
module color_box_blob_centroid_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbbc_pixel_if.sink                      i_pix,
    cbbc_result_if.source                   o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cbbc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cbbc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cbbc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import cbbc_pkg::*;

    t_thresh    w_thresh;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    cbbc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_thresh (w_thresh)
    );

    cbbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    cbbc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thresh (w_thresh),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_pix    (i_pix),
        .o_res    (o_res)
    );
endmodule
